// File: hdl/ihal_pkg.sv
`timescale 1ns / 1ps
package ihal_pkg;

  // Internal byte addresses are kept wide enough that sums of tag sizes never
  // wrap back into the heap, and that a step below zero lands far outside it.
  localparam int AW    = 36;
  localparam int TAG_W = 32;
  localparam int REQ_W = 17;
  localparam int NEED_W = 18;
  localparam int GROW_W = 19;

  localparam logic [TAG_W-1:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [TAG_W-1:0] ALLOC_BIT = 32'h0000_0001;
  localparam logic [NEED_W-1:0] MIN_BLOCK = 18'd16;
  localparam logic [16:0] RESET_CHUNK = 17'd4096;
  localparam int RESET_BREAK = 4112;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Datapath commands.
  localparam logic [4:0] CMD_NOP     = 5'd0;
  localparam logic [4:0] CMD_CLEAR   = 5'd1;
  localparam logic [4:0] CMD_CAPTURE = 5'd2;
  localparam logic [4:0] CMD_DECODE  = 5'd3;
  localparam logic [4:0] CMD_FF      = 5'd4;
  localparam logic [4:0] CMD_GROW    = 5'd5;
  localparam logic [4:0] CMD_GROW2   = 5'd6;
  localparam logic [4:0] CMD_GW2     = 5'd7;
  localparam logic [4:0] CMD_GW3     = 5'd8;
  localparam logic [4:0] CMD_M0      = 5'd9;
  localparam logic [4:0] CMD_M1      = 5'd10;
  localparam logic [4:0] CMD_M2      = 5'd11;
  localparam logic [4:0] CMD_M3      = 5'd12;
  localparam logic [4:0] CMD_M4      = 5'd13;
  localparam logic [4:0] CMD_M5      = 5'd14;
  localparam logic [4:0] CMD_C0      = 5'd15;
  localparam logic [4:0] CMD_C1      = 5'd16;
  localparam logic [4:0] CMD_C2      = 5'd17;
  localparam logic [4:0] CMD_C3      = 5'd18;
  localparam logic [4:0] CMD_C4      = 5'd19;
  localparam logic [4:0] CMD_C5      = 5'd20;
  localparam logic [4:0] CMD_FA      = 5'd21;
  localparam logic [4:0] CMD_FB      = 5'd22;
  localparam logic [4:0] CMD_FIN     = 5'd23;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic req_zero;
    logic addr_zero;
    logic is_free;
    logic ff_zero;
    logic ff_fit;
    logic oom;
    logic merge_skip;
    logic split;
  } dp_flags_t;

  // Contents of a tag word right after reset: prologue, one free block, epilogue.
  function automatic logic [TAG_W-1:0] tag_init(input logic [31:0] idx);
    logic [TAG_W-1:0] v;
    v = '0;
    if (idx == 32'd1 || idx == 32'd2) begin
      v = 32'd8 | ALLOC_BIT;
    end else if (idx == 32'd3 || idx == 32'd1026) begin
      v = 32'd4096;
    end else if (idx == 32'd1027) begin
      v = ALLOC_BIT;
    end
    return v;
  endfunction

endpackage

// File: hdl/ihal_ctrl.sv
`timescale 1ns / 1ps
module ihal_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  input  ihal_pkg::dp_flags_t flags_i,
  output ihal_pkg::dp_cmd_t   cmd_o
);
  import ihal_pkg::*;

  localparam logic [4:0] S_IDLE   = CMD_CAPTURE;
  localparam logic [4:0] S_CLEAR  = CMD_CLEAR;
  localparam logic [4:0] S_DECODE = CMD_DECODE;
  localparam logic [4:0] S_FF     = CMD_FF;
  localparam logic [4:0] S_GROW   = CMD_GROW;
  localparam logic [4:0] S_GROW2  = CMD_GROW2;
  localparam logic [4:0] S_GW2    = CMD_GW2;
  localparam logic [4:0] S_GW3    = CMD_GW3;
  localparam logic [4:0] S_M0     = CMD_M0;
  localparam logic [4:0] S_M1     = CMD_M1;
  localparam logic [4:0] S_M2     = CMD_M2;
  localparam logic [4:0] S_M3     = CMD_M3;
  localparam logic [4:0] S_M4     = CMD_M4;
  localparam logic [4:0] S_M5     = CMD_M5;
  localparam logic [4:0] S_C0     = CMD_C0;
  localparam logic [4:0] S_C1     = CMD_C1;
  localparam logic [4:0] S_C2     = CMD_C2;
  localparam logic [4:0] S_C3     = CMD_C3;
  localparam logic [4:0] S_C4     = CMD_C4;
  localparam logic [4:0] S_C5     = CMD_C5;
  localparam logic [4:0] S_FA     = CMD_FA;
  localparam logic [4:0] S_FB     = CMD_FB;
  localparam logic [4:0] S_FIN    = CMD_FIN;

  logic [4:0] state_q, state_d;
  logic [1:0] fin_q, fin_d;
  logic       out_valid_q, out_valid_d;
  logic       take_in, out_free;

  assign take_in     = (state_q == S_IDLE) && in_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cmd_o.op = state_q;
    cmd_o.fin_status = fin_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        if (flags_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (take_in) begin
          state_d = S_DECODE;
        end else begin
          cmd_o.op = CMD_NOP;
        end
      end
      S_DECODE: begin
        if (flags_i.is_free ? flags_i.addr_zero : flags_i.req_zero) begin
          fin_d   = ST_IGNORED;
          state_d = S_FIN;
        end else begin
          state_d = flags_i.is_free ? S_FA : S_FF;
        end
      end
      S_FF: begin
        if (flags_i.ff_zero) begin
          state_d = S_GROW;
        end else if (flags_i.ff_fit) begin
          state_d = S_C0;
        end
      end
      S_GROW:  state_d = S_GROW2;
      S_GROW2: begin
        if (flags_i.oom) begin
          fin_d   = ST_OOM;
          state_d = S_FIN;
        end else begin
          state_d = S_GW2;
        end
      end
      S_GW2: state_d = S_GW3;
      S_GW3: state_d = S_M0;
      S_M0:  state_d = S_M1;
      S_M1:  state_d = S_M2;
      S_M2:  state_d = S_M3;
      S_M3: begin
        if (flags_i.merge_skip) begin
          fin_d   = ST_DONE;
          state_d = flags_i.is_free ? S_FIN : S_C0;
        end else begin
          state_d = S_M4;
        end
      end
      S_M4: state_d = S_M5;
      S_M5: begin
        fin_d   = ST_DONE;
        state_d = flags_i.is_free ? S_FIN : S_C0;
      end
      S_C0: state_d = S_C1;
      S_C1: state_d = S_C2;
      S_C2: state_d = S_C3;
      S_C3: begin
        fin_d   = ST_DONE;
        state_d = flags_i.split ? S_C4 : S_FIN;
      end
      S_C4: state_d = S_C5;
      S_C5: begin
        fin_d   = ST_DONE;
        state_d = S_FIN;
      end
      S_FA: state_d = S_FB;
      S_FB: state_d = S_M0;
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cmd_o.op = CMD_NOP;
        end
      end
      default: begin
        cmd_o.op = CMD_NOP;
        state_d  = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fin_q       <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_in |=> state_q == S_DECODE)
    else $error("accepted item did not move to decode");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished item was not posted");

  a_fin_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fin_q == ST_DONE || fin_q == ST_OOM || fin_q == ST_IGNORED))
    else $error("bad status code");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !flags_i.clear_done) |=> state_q == S_CLEAR)
    else $error("clearing pass left early");

endmodule

// File: hdl/ihal_dp.sv
`timescale 1ns / 1ps
module ihal_dp #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ihal_pkg::dp_cmd_t   cmd_i,
  output ihal_pkg::dp_flags_t flags_o,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_chunk_i,
  input  logic                op_i,
  input  logic [16:0]         request_bytes_i,
  input  logic [15:0]         block_address_i,
  output logic [1:0]          status_o,
  output logic [15:0]         payload_address_o
);
  import ihal_pkg::*;

  localparam int DEPTH = (HEAP_BYTES + 3) / 4;
  localparam int IW    = $clog2(DEPTH);
  localparam int BW    = $clog2(HEAP_BYTES + 1);
  localparam logic [AW-1:0] HEAP_A = AW'(HEAP_BYTES);

  logic [TAG_W-1:0] mem_q [DEPTH];
  logic [TAG_W-1:0] mem_rd_q;
  logic             rd_ok_q;
  logic [IW-1:0]    clr_cnt_q;

  logic              op_q;
  logic [REQ_W-1:0]  req_q;
  logic [AW-1:0]     p_q, size_q, nxt_q;
  logic [TAG_W-1:0]  psize_q, nsize_q, have_q;
  logic [NEED_W-1:0] need_q;
  logic [GROW_W-1:0] grow_q;
  logic [BW-1:0]     brk_q;
  logic [16:0]       chunk_q;
  logic              pa_q, na_q, split_q;

  logic [TAG_W-1:0]  rdata, rsize;
  logic              ralloc;
  logic              rd_en, we;
  logic [AW-1:0]     raddr, waddr;
  logic [TAG_W-1:0]  wdata;
  logic [AW-1:0]     rsize_a, blk_a, grow_a;
  logic [NEED_W-1:0] need_calc, ext;
  logic [NEED_W:0]   req_sum;
  logic [AW-1:0]     merge_sum;
  logic [TAG_W-1:0]  carve_sz;

  assign rdata   = rd_ok_q ? mem_rd_q : '0;
  assign rsize   = rdata & SIZE_MASK;
  assign ralloc  = rdata[0];
  assign rsize_a = AW'(rsize);
  assign grow_a  = AW'(grow_q);

  // Block size for the request: header and footer added, rounded to 8.
  assign req_sum   = (NEED_W+1)'(req_q) + (NEED_W+1)'(15);
  assign need_calc = (req_q <= REQ_W'(8)) ? MIN_BLOCK
                   : NEED_W'({req_sum[NEED_W:3], 3'b000});
  assign ext = (need_q > NEED_W'(chunk_q)) ? need_q : NEED_W'(chunk_q);

  assign merge_sum = pa_q ? (size_q + rsize_a)
                   : (ralloc ? (size_q + AW'(psize_q))
                             : (size_q + AW'(psize_q) + rsize_a));
  assign carve_sz = split_q ? TAG_W'(need_q) : have_q;
  assign blk_a    = AW'(brk_q);

  assign flags_o.clear_done = (clr_cnt_q == IW'(DEPTH - 1));
  assign flags_o.req_zero   = (req_q == '0);
  assign flags_o.addr_zero  = (p_q == '0);
  assign flags_o.is_free    = op_q;
  assign flags_o.ff_zero    = (rsize == '0);
  assign flags_o.ff_fit     = !ralloc && (TAG_W'(need_q) <= rsize);
  assign flags_o.oom        = (blk_a + grow_a) > HEAP_A;
  assign flags_o.merge_skip = pa_q && ralloc;
  assign flags_o.split      = split_q;

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (cmd_i.op)
      CMD_DECODE: begin
        rd_en = 1'b1;
        raddr = op_q ? (p_q - AW'(4)) : AW'(4);
      end
      CMD_FF: begin
        rd_en = 1'b1;
        raddr = p_q + rsize_a - AW'(4);
      end
      CMD_GROW2: begin
        we    = !flags_o.oom;
        waddr = blk_a - AW'(4);
        wdata = TAG_W'(grow_q);
      end
      CMD_GW2: begin
        we    = 1'b1;
        waddr = p_q + grow_a - AW'(8);
        wdata = TAG_W'(grow_q);
      end
      CMD_GW3: begin
        we    = 1'b1;
        waddr = p_q + grow_a - AW'(4);
        wdata = ALLOC_BIT;
      end
      CMD_M0, CMD_C0: begin
        rd_en = 1'b1;
        raddr = p_q - AW'(4);
      end
      CMD_M1: begin
        rd_en = 1'b1;
        raddr = p_q - AW'(8);
      end
      CMD_M2: begin
        rd_en = 1'b1;
        raddr = nxt_q - AW'(4);
      end
      CMD_M4: begin
        we    = 1'b1;
        wdata = size_q[TAG_W-1:0];
        if (pa_q) begin
          waddr = p_q - AW'(4);
        end else if (na_q) begin
          waddr = nxt_q - AW'(8);
        end else begin
          waddr = nxt_q + AW'(nsize_q) - AW'(8);
        end
      end
      CMD_M5: begin
        we    = 1'b1;
        wdata = size_q[TAG_W-1:0];
        waddr = pa_q ? (p_q + size_q - AW'(8)) : (p_q - AW'(psize_q) - AW'(4));
      end
      CMD_C2: begin
        we    = 1'b1;
        waddr = p_q - AW'(4);
        wdata = carve_sz | ALLOC_BIT;
      end
      CMD_C3: begin
        we    = 1'b1;
        waddr = p_q + AW'(carve_sz) - AW'(8);
        wdata = carve_sz | ALLOC_BIT;
      end
      CMD_C4: begin
        we    = 1'b1;
        waddr = p_q + AW'(need_q) - AW'(4);
        wdata = have_q - TAG_W'(need_q);
      end
      CMD_C5: begin
        we    = 1'b1;
        waddr = p_q + AW'(have_q) - AW'(8);
        wdata = have_q - TAG_W'(need_q);
      end
      CMD_FA: begin
        we    = 1'b1;
        waddr = p_q - AW'(4);
        wdata = rsize;
      end
      CMD_FB: begin
        we    = 1'b1;
        waddr = p_q + size_q - AW'(8);
        wdata = size_q[TAG_W-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Tag store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_CLEAR) begin
      mem_q[clr_cnt_q] <= tag_init(32'(clr_cnt_q));
    end else if (we && (waddr < HEAP_A)) begin
      mem_q[waddr[IW+1:2]] <= wdata;
    end
    if (rd_en && (raddr < HEAP_A)) begin
      mem_rd_q <= mem_q[raddr[IW+1:2]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q   <= 1'b0;
      clr_cnt_q <= '0;
      brk_q     <= BW'(RESET_BREAK);
      chunk_q   <= RESET_CHUNK;
    end else begin
      if (rd_en) rd_ok_q <= (raddr < HEAP_A);
      if (cmd_i.op == CMD_CLEAR && !flags_o.clear_done) clr_cnt_q <= clr_cnt_q + IW'(1);
      if (cmd_i.op == CMD_GROW2 && !flags_o.oom) brk_q <= BW'(blk_a + grow_a);
      if (cfg_we_i) chunk_q <= cfg_chunk_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_CAPTURE: begin
        op_q  <= op_i;
        req_q <= request_bytes_i;
        p_q   <= AW'(block_address_i);
      end
      CMD_DECODE: begin
        need_q <= need_calc;
        if (!op_q) p_q <= AW'(8);
      end
      CMD_FF: begin
        if (!flags_o.ff_fit) p_q <= p_q + rsize_a;
      end
      CMD_GROW: begin
        grow_q <= GROW_W'({1'b0, ext[NEED_W-1:3]} + GROW_W'(ext[2])) << 3;
      end
      CMD_GROW2: begin
        p_q <= blk_a;
      end
      CMD_M1: begin
        size_q <= rsize_a;
        nxt_q  <= p_q + rsize_a;
      end
      CMD_M2: begin
        pa_q    <= ralloc;
        psize_q <= rsize;
      end
      CMD_M3: begin
        na_q    <= ralloc;
        nsize_q <= rsize;
        size_q  <= merge_sum;
      end
      CMD_M5: begin
        if (!pa_q) p_q <= p_q - AW'(psize_q);
      end
      CMD_C1: begin
        have_q  <= rsize;
        split_q <= (AW'(rsize) >= AW'(need_q) + AW'(MIN_BLOCK));
      end
      CMD_FA: begin
        size_q <= rsize_a;
      end
      CMD_FIN: begin
        status_o          <= cmd_i.fin_status;
        payload_address_o <= (cmd_i.fin_status == ST_DONE && !op_q) ? p_q[15:0] : '0;
      end
      default: begin
        na_q <= na_q;
      end
    endcase
  end

endmodule

// File: hdl/implicit_list_heap_allocator.sv
`timescale 1ns / 1ps
// First-fit heap allocator over an implicit block list with boundary tags.
// The heap lives in an internal tag memory of HEAP_BYTES/4 words; every block
// carries a header and a footer word holding its size and an allocated bit.
// An item with op 0 asks for request_bytes of payload: the request is rounded
// to an 8-byte aligned block of at least 16 bytes, the block list is walked
// from the start, and the first free block that is large enough is taken and
// split when 16 bytes or more remain. When no block fits, the heap break is
// raised by the larger of the block and grow_chunk_bytes and the new space is
// merged with a free block in front of it; if that would pass HEAP_BYTES the
// result has out-of-memory status. An item with op 1 frees the block at
// block_address and merges it with free neighbors. A zero-size request or a
// null free is returned with the ignored status and changes nothing. No check
// is made on the address of a free. Each item returns exactly one result.
// Timing: after reset the block runs a clearing pass over every word of the
// tag memory before it takes its first item; configuration writes are taken
// during that pass. The walk is set by the single read port of the tag
// memory, which looks at one block header per cycle. A finished result waits
// while the output register still holds an unaccepted item. The next item can
// be accepted at the first edge after its predecessor's result is posted.
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [16:0] request_bytes_i,
  input  logic [15:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] payload_address_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] grow_chunk_bytes_i
);
  import ihal_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  // The growth register may be rewritten at any time; software writes it
  // only while the block is idle.
  assign cfg_ready_o = 1'b1;

  // The controller sequences one item at a time through the tag memory.
  ihal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  // The datapath holds the tag memory, the walk pointers and the results.
  ihal_dp #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .flags_o          (flags),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_chunk_i      (grow_chunk_bytes_i),
    .op_i             (op_i),
    .request_bytes_i  (request_bytes_i),
    .block_address_i  (block_address_i),
    .status_o         (status_o),
    .payload_address_o(payload_address_o)
  );

endmodule
